// File: hdl/mcet_pkg.sv
// Shared types and constants of the multi-channel event timer.
// Field widths, operation codes, slot record layout and the arithmetic unit's operand groups.
// Depends on nothing; mcet_channels.sv, mcet_alu and the top level refer to it, mcet_ram does not.
package mcet_pkg;

   localparam int OP_W           = 2;
   localparam int TIME_W         = 32;
   localparam int TAG_W          = 8;
   localparam int ID_W           = 5;
   localparam int NUM_TIMERS_DEF = 16;

   localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
   localparam logic [OP_W-1:0] OP_PAUSE  = 2'd3;

   localparam logic KIND_CREATED = 1'b0;
   localparam logic KIND_FIRED   = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0] interval;
      logic              periodic;
      logic [TAG_W-1:0]  tag;
   } slot_info_type;

   typedef struct packed {
      logic [TIME_W-1:0] add_a;
      logic [TIME_W-1:0] add_b;
      logic [TIME_W-1:0] sub_a;
      logic [TIME_W-1:0] sub_b;
   } alu_in_type;

   typedef struct packed {
      logic [TIME_W-1:0] add_sum;
      logic [TIME_W-1:0] sub_diff;
      logic              sub_gt;
   } alu_out_type;

endpackage

// File: hdl/mcet_channels.sv
// Handshake channels of the event timer: the request channel and the response channel.
// Each carries valid, ready and one beat of payload; widths come from mcet_pkg.
interface mcet_req_if;
   logic                         valid;
   logic                         ready;
   logic [mcet_pkg::OP_W-1:0]    operation;
   logic [mcet_pkg::TIME_W-1:0]  now;
   logic [mcet_pkg::TIME_W-1:0]  amount;
   logic                         repeat_req;
   logic [mcet_pkg::TAG_W-1:0]   event_tag;
   logic [mcet_pkg::ID_W-1:0]    timer_id;

   modport source (output valid, output operation, output now, output amount,
                   output repeat_req, output event_tag, output timer_id, input ready);
   modport sink (input valid, input operation, input now, input amount,
                 input repeat_req, input event_tag, input timer_id, output ready);
endinterface

interface mcet_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [mcet_pkg::ID_W-1:0]   fired_id;
   logic [mcet_pkg::TAG_W-1:0]  tag_out;
   logic                        last;

   modport source (output valid, output kind, output fired_id, output tag_out,
                   output last, input ready);
   modport sink (input valid, input kind, input fired_id, input tag_out,
                 input last, output ready);
endinterface

// File: hdl/mcet_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the per-slot records of the event timer; no dependencies.
module mcet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mcet_alu.sv
// Shared time arithmetic of the event timer: a saturating adder and a clamping subtractor.
// The subtractor also gives the strict greater-than used by the slot scan. Uses mcet_pkg.
module mcet_alu (
   input  mcet_pkg::alu_in_type  alu_in,
   output mcet_pkg::alu_out_type alu_out
);

   localparam int TIME_W = mcet_pkg::TIME_W;

   logic [TIME_W:0] sum;
   logic [TIME_W:0] diff;

   always_comb begin
      sum  = {1'b0, alu_in.add_a} + {1'b0, alu_in.add_b};
      diff = {1'b0, alu_in.sub_a} - {1'b0, alu_in.sub_b};
      alu_out.add_sum  = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
      alu_out.sub_diff = diff[TIME_W] ? '0 : diff[TIME_W-1:0];
      alu_out.sub_gt   = !diff[TIME_W] && (diff[TIME_W-1:0] != '0);
   end

endmodule

// File: hdl/multi_channel_event_timer.sv
// Multi-channel event timer: a table of one-shot and periodic timer slots.
// Uses mcet_pkg, the channels in mcet_channels.sv, mcet_ram and mcet_alu.
//
// Requests arrive as beats on req and results leave as beats on rsp. A create beat
// answers one beat with the new id and tag, passing through the create state and the
// output register. Remove and pause beats give no result. A tick beat scans the slots
// in index order, one slot per cycle unless a stalled receiver holds it, through one
// shared adder and comparator, then hands the final beat to the output register in the
// flush state; every due timer yields a beat, the final one marked by last.
// The block takes one request at a time; req.ready is high only between requests.
// Results leave through an output register, and one due timer waits in a holding
// register so that the last flag can be set once the scan is complete. When the
// receiver stalls, the scan halts at the next due timer until the output register frees.
// Reset frees all slots and clears the id counter and the pause offset; no clearing
// pass is needed, so a request is accepted in the first cycle after reset.
module multi_channel_event_timer #(
   parameter int NUM_TIMERS = mcet_pkg::NUM_TIMERS_DEF
) (
   input logic         clock,
   input logic         reset,
   mcet_req_if.sink    req,
   mcet_rsp_if.source  rsp
);

   localparam int TIME_W = mcet_pkg::TIME_W;
   localparam int TAG_W  = mcet_pkg::TAG_W;
   localparam int ID_W   = mcet_pkg::ID_W;
   localparam int IDX_W  = $clog2(NUM_TIMERS);
   localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
   localparam int INFO_W = $bits(mcet_pkg::slot_info_type);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CREATE = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FLUSH  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [TIME_W-1:0]     cur_ff, cur_in;
   logic [TIME_W-1:0]     amount_ff, amount_in;
   logic                  repeat_ff, repeat_in;
   logic [TAG_W-1:0]      tag_ff, tag_in;
   logic [TIME_W-1:0]     pause_ff, pause_in;
   logic [CNT_W-1:0]      last_id_ff, last_id_in;
   logic [NUM_TIMERS-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  held_valid_ff, held_valid_in;
   logic [ID_W-1:0]       held_id_ff, held_id_in;
   logic [TAG_W-1:0]      held_tag_ff, held_tag_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_kind_ff, out_kind_in;
   logic [ID_W-1:0]       out_id_ff, out_id_in;
   logic [TAG_W-1:0]      out_tag_ff, out_tag_in;
   logic                  out_last_ff, out_last_in;

   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic                  tgt_wr_en;
   logic [TIME_W-1:0]     tgt_wr_data;
   logic [TIME_W-1:0]     tgt_rd_data;
   logic                  info_wr_en;
   logic [INFO_W-1:0]     info_wr_data;
   logic [INFO_W-1:0]     info_rd_data;
   mcet_pkg::slot_info_type rd_info;
   mcet_pkg::slot_info_type new_info;

   mcet_pkg::alu_in_type  alu_in;
   mcet_pkg::alu_out_type alu_out;

   logic                  req_take;
   logic                  out_free;
   logic [CNT_W-1:0]      next_id;
   logic                  fire;
   logic                  advance;

   mcet_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   mcet_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TIMERS)) u_target_ram (
      .clock   (clock),
      .wr_en   (tgt_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (tgt_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (tgt_rd_data)
   );

   mcet_ram #(.WIDTH(INFO_W), .DEPTH(NUM_TIMERS)) u_info_ram (
      .clock   (clock),
      .wr_en   (info_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (info_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (info_rd_data)
   );

   assign req.ready    = (state_ff == ST_IDLE);
   assign rsp.valid    = out_valid_ff;
   assign rsp.kind     = out_kind_ff;
   assign rsp.fired_id = out_id_ff;
   assign rsp.tag_out  = out_tag_ff;
   assign rsp.last     = out_last_ff;

   assign req_take = req.valid && req.ready;
   assign out_free = !out_valid_ff || rsp.ready;
   assign next_id  = (last_id_ff == CNT_W'(NUM_TIMERS)) ? CNT_W'(1) : CNT_W'(last_id_ff + 1'b1);
   assign rd_info  = mcet_pkg::slot_info_type'(info_rd_data);
   assign fire     = valid_ff[idx_ff] && alu_out.sub_gt;
   assign advance  = !(fire && held_valid_ff && !out_free);

   always_comb begin
      new_info.interval = amount_ff;
      new_info.periodic = repeat_ff;
      new_info.tag      = tag_ff;
      info_wr_data      = INFO_W'(new_info);
   end

   // Operand selection for the shared unit.
   always_comb begin
      alu_in.add_a = pause_ff;
      alu_in.add_b = req.amount;
      alu_in.sub_a = req.now;
      alu_in.sub_b = pause_ff;
      case (state_ff)
         ST_CREATE: begin
            alu_in.add_a = cur_ff;
            alu_in.add_b = amount_ff;
         end
         ST_SCAN: begin
            alu_in.add_a = tgt_rd_data;
            alu_in.add_b = rd_info.interval;
            alu_in.sub_a = cur_ff;
            alu_in.sub_b = tgt_rd_data;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      amount_in     = amount_ff;
      repeat_in     = repeat_ff;
      tag_in        = tag_ff;
      pause_in      = pause_ff;
      last_id_in    = last_id_ff;
      valid_in      = valid_ff;
      idx_in        = idx_ff;
      held_valid_in = held_valid_ff;
      held_id_in    = held_id_ff;
      held_tag_in   = held_tag_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_kind_in   = out_kind_ff;
      out_id_in     = out_id_ff;
      out_tag_in    = out_tag_ff;
      out_last_in   = out_last_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff;
      ram_wr_addr   = idx_ff;
      tgt_wr_en     = 1'b0;
      tgt_wr_data   = alu_out.add_sum;
      info_wr_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // Slot zero is read ahead so that a scan starts at once.
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            if (req_take) begin
               case (req.operation)
                  mcet_pkg::OP_CREATE: begin
                     cur_in    = alu_out.sub_diff;
                     amount_in = req.amount;
                     repeat_in = req.repeat_req;
                     tag_in    = req.event_tag;
                     state_in  = ST_CREATE;
                  end
                  mcet_pkg::OP_REMOVE: begin
                     if ((req.timer_id != '0) && (32'(req.timer_id) <= NUM_TIMERS)) begin
                        valid_in[IDX_W'(req.timer_id - 1'b1)] = 1'b0;
                     end
                  end
                  mcet_pkg::OP_TICK: begin
                     cur_in   = alu_out.sub_diff;
                     idx_in   = '0;
                     state_in = ST_SCAN;
                  end
                  mcet_pkg::OP_PAUSE: begin
                     pause_in = alu_out.add_sum;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CREATE: begin
            if (out_free) begin
               ram_wr_addr                      = IDX_W'(next_id - 1'b1);
               tgt_wr_en                        = 1'b1;
               info_wr_en                       = 1'b1;
               valid_in[IDX_W'(next_id - 1'b1)] = 1'b1;
               last_id_in                       = next_id;
               out_valid_in                     = 1'b1;
               out_kind_in                      = mcet_pkg::KIND_CREATED;
               out_id_in                        = ID_W'(next_id);
               out_tag_in                       = tag_ff;
               out_last_in                      = 1'b1;
               state_in                         = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (advance) begin
               if (fire) begin
                  if (held_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_kind_in  = mcet_pkg::KIND_FIRED;
                     out_id_in    = held_id_ff;
                     out_tag_in   = held_tag_ff;
                     out_last_in  = 1'b0;
                  end
                  held_valid_in = 1'b1;
                  held_id_in    = ID_W'(CNT_W'(idx_ff) + 1'b1);
                  held_tag_in   = rd_info.tag;
                  if (rd_info.periodic) begin
                     tgt_wr_en = 1'b1;
                  end else begin
                     valid_in[idx_ff] = 1'b0;
                  end
               end
               if (idx_ff == IDX_W'(NUM_TIMERS - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in      = IDX_W'(idx_ff + 1'b1);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = IDX_W'(idx_ff + 1'b1);
               end
            end
         end
         ST_FLUSH: begin
            if (!held_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = mcet_pkg::KIND_FIRED;
               out_id_in     = held_id_ff;
               out_tag_in    = held_tag_ff;
               out_last_in   = 1'b1;
               held_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pause_ff      <= '0;
         last_id_ff    <= '0;
         valid_ff      <= '0;
         idx_ff        <= '0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pause_ff      <= pause_in;
         last_id_ff    <= last_id_in;
         valid_ff      <= valid_in;
         idx_ff        <= idx_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      amount_ff   <= amount_in;
      repeat_ff   <= repeat_in;
      tag_ff      <= tag_in;
      held_id_ff  <= held_id_in;
      held_tag_ff <= held_tag_in;
      out_kind_ff <= out_kind_in;
      out_id_ff   <= out_id_in;
      out_tag_ff  <= out_tag_in;
      out_last_ff <= out_last_in;
   end

`ifndef ASSERT_OFF
   a_idle_no_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !held_valid_ff)
      else $error("holding register still full between requests");

   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !advance) |-> (held_valid_ff && out_valid_ff && !rsp.ready))
      else $error("scan stalled without a full output path");

   a_create_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == mcet_pkg::KIND_CREATED) |-> out_last_ff)
      else $error("create answer beat without last");

   a_id_range: assert property (@(posedge clock) disable iff (reset)
      32'(last_id_ff) <= NUM_TIMERS)
      else $error("issued id beyond the slot count");

   a_create_next: assert property (@(posedge clock) disable iff (reset)
      (req_take && req.operation == mcet_pkg::OP_CREATE) |=> (state_ff == ST_CREATE))
      else $error("accepted create did not start");
`endif

endmodule
